// ----- hdl/fnv_length_frame_checker_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the frame checker parser.
// ----------------------------------------------------------------------------
`ifndef FNV_LENGTH_FRAME_CHECKER_ASSERT_SVH
`define FNV_LENGTH_FRAME_CHECKER_ASSERT_SVH

// same-cycle implication
`define FLC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/flc_pkg.sv -----
// ----------------------------------------------------------------------------
// flc_pkg
// Types and constants of the length-prefixed FNV-1a frame checker.
// ----------------------------------------------------------------------------
package flc_pkg;

  localparam logic [31:0] FnvBasis = 32'h811C_9DC5;
  localparam logic [31:0] FnvPrime = 32'h0100_0193;

  localparam int unsigned LenW = 25;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DROPPED = 2'd2
  } flc_phase_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_OVERSIZE = 2'd2
  } flc_status_e;

  typedef struct packed {
    logic       new_connection;
    logic [7:0] rx_byte;
  } flc_item_t;

endpackage

// ----- hdl/flc_ifs.sv -----
// ----------------------------------------------------------------------------
// flc interfaces
// Valid/ready channels for received bytes, results and the limit register.
// ----------------------------------------------------------------------------
interface flc_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       new_connection;

  modport source (output valid, output rx_byte, output new_connection, input ready);
  modport sink   (input valid, input rx_byte, input new_connection, output ready);
endinterface

interface flc_res_if;
  logic                 valid;
  logic                 ready;
  logic [7:0]           payload_byte;
  logic                 byte_present;
  logic                 frame_end;
  flc_pkg::flc_status_e frame_status;

  modport source (output valid, output payload_byte, output byte_present,
                  output frame_end, output frame_status, input ready);
  modport sink   (input valid, input payload_byte, input byte_present,
                  input frame_end, input frame_status, output ready);
endinterface

interface flc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [flc_pkg::LenW-1:0]   max_length;

  modport source (output valid, output max_length, input ready);
  modport sink   (input valid, input max_length, output ready);
endinterface

// ----- hdl/fnv_length_frame_checker.sv -----
// ----------------------------------------------------------------------------
// fnv_length_frame_checker
// Length-prefixed frame parser with FNV-1a 32 payload check.
// ----------------------------------------------------------------------------
// Takes one received byte per clock unless results stall, and returns at
// most one result per byte, via the input and then the result register.
// Sustained rate is one byte per cycle while results are taken; it is set
// by the flc_parser state update; the FNV-1a multiply is a shift-add tree.
// Each frame is an 8-byte little-endian header (length, then checksum);
// payload bytes are forwarded as they arrive, and the last one carries the
// frame status, so the consumer must discard any frame that ends bad. After
// an error no results are produced until a transaction with new_connection
// set. Writes to max_length above MAX_FRAME_LIMIT saturate; write the limit
// only while the block is idle.
module fnv_length_frame_checker #(
  parameter int unsigned MAX_FRAME_LIMIT = 16777216
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  flc_rx_if.sink     rx_i,
  flc_res_if.source  res_o,
  flc_cfg_if.sink    cfg_i
);

  localparam logic [flc_pkg::LenW-1:0] LimitW = flc_pkg::LenW'(MAX_FRAME_LIMIT);

  logic [flc_pkg::LenW-1:0] max_len_q, max_len_d;
  logic                     advance;
  logic                     item_valid;
  flc_pkg::flc_item_t       item;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    max_len_d = max_len_q;
    if (cfg_i.valid) begin
      max_len_d = (cfg_i.max_length > LimitW) ? LimitW : cfg_i.max_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= LimitW;
    end else begin
      max_len_q <= max_len_d;
    end
  end

  flc_input_reg u_input_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx_i),
    .advance_i   (advance),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  flc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .max_length_i(max_len_q),
    .advance_o   (advance),
    .res         (res_o)
  );

endmodule

// ----- hdl/flc_input_reg.sv -----
// ----------------------------------------------------------------------------
// flc_input_reg
// Input register stage; holds one received transaction until the parser takes it.
// ----------------------------------------------------------------------------
module flc_input_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  flc_rx_if.sink             rx,
  input  logic               advance_i,
  output logic               item_valid_o,
  output flc_pkg::flc_item_t item_o
);

  logic               valid_q, valid_d;
  flc_pkg::flc_item_t item_q;
  logic               take;

  assign rx.ready = !valid_q || advance_i;
  assign take     = rx.valid && rx.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.rx_byte        <= rx.rx_byte;
      item_q.new_connection <= rx.new_connection;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- hdl/flc_parser.sv -----
// ----------------------------------------------------------------------------
// flc_parser
// Frame parse state, FNV-1a update and the result register.
// ----------------------------------------------------------------------------
`include "fnv_length_frame_checker_assert.svh"

module flc_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     item_valid_i,
  input  flc_pkg::flc_item_t       item_i,
  input  logic [flc_pkg::LenW-1:0] max_length_i,
  output logic                     advance_o,
  flc_res_if.source                res
);

  // h * 0x01000193 as shifts and adds
  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'b0, b};
    return x + (x << 1) + (x << 4) + (x << 7) + (x << 8) + (x << 24);
  endfunction

  flc_pkg::flc_phase_e       phase_q, phase_d;
  logic [2:0]                hdr_cnt_q, hdr_cnt_d;
  logic [31:0]               frame_len_q, frame_len_d;
  logic [31:0]               exp_hash_q, exp_hash_d;
  logic [31:0]               run_hash_q, run_hash_d;
  logic [flc_pkg::LenW-1:0]  left_q, left_d;

  logic                      res_valid_q, res_valid_d;
  logic [7:0]                res_byte_q;
  logic                      res_present_q;
  logic                      res_end_q;
  flc_pkg::flc_status_e      res_status_q;

  logic                      emit;
  logic [7:0]                emit_byte;
  logic                      emit_present;
  logic                      emit_end;
  flc_pkg::flc_status_e      emit_status;

  logic                      step;
  logic [31:0]               len_nx, hash_nx, new_hash;
  logic [flc_pkg::LenW-1:0]  left_dec;
  logic [4:0]                sh;

  assign advance_o = !res_valid_q || res.ready;
  assign step      = item_valid_i && advance_o;
  assign sh        = {hdr_cnt_q[1:0], 3'b000};
  assign len_nx    = hdr_cnt_q[2] ? frame_len_q
                                  : (frame_len_q | ({24'b0, item_i.rx_byte} << sh));
  assign hash_nx   = hdr_cnt_q[2] ? (exp_hash_q | ({24'b0, item_i.rx_byte} << sh))
                                  : exp_hash_q;
  assign new_hash  = fnv_step(run_hash_q, item_i.rx_byte);
  assign left_dec  = (left_q != '0) ? left_q - 1'b1 : left_q;

  always_comb begin
    phase_d      = phase_q;
    hdr_cnt_d    = hdr_cnt_q;
    frame_len_d  = frame_len_q;
    exp_hash_d   = exp_hash_q;
    run_hash_d   = run_hash_q;
    left_d       = left_q;
    emit         = 1'b0;
    emit_byte    = 8'd0;
    emit_present = 1'b0;
    emit_end     = 1'b0;
    emit_status  = flc_pkg::ST_OK;
    if (step) begin
      if (item_i.new_connection) begin
        phase_d     = flc_pkg::PH_HEADER;
        hdr_cnt_d   = 3'd0;
        frame_len_d = 32'd0;
        exp_hash_d  = 32'd0;
        run_hash_d  = flc_pkg::FnvBasis;
        left_d      = '0;
      end else begin
        case (phase_q)
          flc_pkg::PH_HEADER: begin
            frame_len_d = len_nx;
            exp_hash_d  = hash_nx;
            if (hdr_cnt_q != 3'd7) begin
              hdr_cnt_d = hdr_cnt_q + 3'd1;
            end else begin
              hdr_cnt_d  = 3'd0;
              run_hash_d = flc_pkg::FnvBasis;
              if (len_nx > {{(32 - flc_pkg::LenW){1'b0}}, max_length_i}) begin
                phase_d     = flc_pkg::PH_DROPPED;
                emit        = 1'b1;
                emit_end    = 1'b1;
                emit_status = flc_pkg::ST_OVERSIZE;
              end else if (len_nx == 32'd0) begin
                emit        = 1'b1;
                emit_end    = 1'b1;
                emit_status = (hash_nx == flc_pkg::FnvBasis) ? flc_pkg::ST_OK
                                                             : flc_pkg::ST_MISMATCH;
                phase_d     = (hash_nx == flc_pkg::FnvBasis) ? flc_pkg::PH_HEADER
                                                             : flc_pkg::PH_DROPPED;
                frame_len_d = 32'd0;
                exp_hash_d  = 32'd0;
              end else begin
                left_d  = len_nx[flc_pkg::LenW-1:0];
                phase_d = flc_pkg::PH_PAYLOAD;
              end
            end
          end
          flc_pkg::PH_PAYLOAD: begin
            emit         = 1'b1;
            emit_byte    = item_i.rx_byte;
            emit_present = 1'b1;
            left_d       = left_dec;
            if (left_dec != '0) begin
              run_hash_d = new_hash;
            end else begin
              emit_end    = 1'b1;
              emit_status = (new_hash == exp_hash_q) ? flc_pkg::ST_OK
                                                     : flc_pkg::ST_MISMATCH;
              phase_d     = (new_hash == exp_hash_q) ? flc_pkg::PH_HEADER
                                                     : flc_pkg::PH_DROPPED;
              hdr_cnt_d   = 3'd0;
              frame_len_d = 32'd0;
              exp_hash_d  = 32'd0;
              run_hash_d  = flc_pkg::FnvBasis;
            end
          end
          default: begin
            // dropped: wait for a new connection
          end
        endcase
      end
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance_o) begin
      res_valid_d = emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= flc_pkg::PH_HEADER;
      hdr_cnt_q   <= 3'd0;
      frame_len_q <= 32'd0;
      exp_hash_q  <= 32'd0;
      run_hash_q  <= flc_pkg::FnvBasis;
      left_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      frame_len_q <= frame_len_d;
      exp_hash_q  <= exp_hash_d;
      run_hash_q  <= run_hash_d;
      left_q      <= left_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_byte_q    <= emit_byte;
      res_present_q <= emit_present;
      res_end_q     <= emit_end;
      res_status_q  <= emit_status;
    end
  end

  assign res.valid        = res_valid_q;
  assign res.payload_byte = res_byte_q;
  assign res.byte_present = res_present_q;
  assign res.frame_end    = res_end_q;
  assign res.frame_status = res_status_q;

  `FLC_ASSERT_IMPL(a_payload_left, clk_i, rst_ni, phase_q == flc_pkg::PH_PAYLOAD,
                   left_q != '0, "payload phase with no bytes left")
  `FLC_ASSERT_IMPL(a_hdr_cnt_phase, clk_i, rst_ni, hdr_cnt_q != 3'd0,
                   phase_q == flc_pkg::PH_HEADER, "header count outside header phase")
  `FLC_ASSERT_IMPL(a_empty_is_end, clk_i, rst_ni, res_valid_q && !res_present_q,
                   res_end_q, "byte-less result that does not end a frame")
  `FLC_ASSERT_IMPL(a_bad_is_end, clk_i, rst_ni,
                   res_valid_q && res_status_q != flc_pkg::ST_OK,
                   res_end_q, "error status without frame end")
  `FLC_ASSERT_NEXT(a_oversize_drops, clk_i, rst_ni,
                   step && emit && emit_status == flc_pkg::ST_OVERSIZE,
                   phase_q == flc_pkg::PH_DROPPED && res_valid_q,
                   "oversize did not enter dropped mode")

endmodule
